// ===== rtl/eppc_pkg.sv =====
// ============================================================================
// EAP packet parse/classify package
// Shared types and constants for the EAP header parser and its channels.
// ============================================================================
package eppc_pkg;

    // EAP code values.
    localparam logic [7:0] CODE_REQUEST  = 8'd1;
    localparam logic [7:0] CODE_RESPONSE = 8'd2;
    localparam logic [7:0] CODE_SUCCESS  = 8'd3;
    localparam logic [7:0] CODE_FAILURE  = 8'd4;

    // EAP type values.
    localparam logic [7:0] TYPE_IDENTITY = 8'd1;
    localparam logic [7:0] TYPE_MD5      = 8'd4;

    // Header geometry.
    localparam logic [15:0] HDR_LEN       = 16'd4;
    localparam logic [15:0] REQ_MIN_LEN   = 16'd5;
    localparam logic [15:0] CHAL_VAL_OFS  = 16'd6;
    localparam logic [15:0] CNT_MAX       = 16'hFFFF;

    // Byte offsets of the captured header fields.
    localparam logic [15:0] OFS_CODE      = 16'd0;
    localparam logic [15:0] OFS_IDENT     = 16'd1;
    localparam logic [15:0] OFS_LEN_HI    = 16'd2;
    localparam logic [15:0] OFS_LEN_LO    = 16'd3;
    localparam logic [15:0] OFS_TYPE      = 16'd4;
    localparam logic [15:0] OFS_VAL_SIZE  = 16'd5;

    // Event class of a finished packet.
    typedef enum logic [2:0] {
        EV_SUCCESS     = 3'd0,
        EV_FAILURE     = 3'd1,
        EV_IDENTITY    = 3'd2,
        EV_MD5_CHAL    = 3'd3,
        EV_UNSUPPORTED = 3'd4
    } t_event;

    // One input beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    // One result beat.
    typedef struct packed {
        logic        status;
        t_event      event_res;
        logic [7:0]  code;
        logic [7:0]  identifier;
        logic [15:0] packet_length;
        logic [7:0]  eap_type;
        logic        challenge_valid;
        logic [7:0]  challenge_length;
    } t_out_beat;

endpackage

// ===== rtl/eppc_if.sv =====
// ============================================================================
// EAP parser stream channels
// Valid/ready channels carrying input byte beats and result beats.
// ============================================================================
interface eppc_in_if;
    import eppc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface eppc_out_if;
    import eppc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/eap_packet_parse_classify_unit.sv =====
// A result is valid in the cycle after the beat that carries last_byte.
// Throughput: one byte beat per cycle; the result register is the only stall
// point, and input is held off only while a result waits and o_out.ready is low.
// Reset (i_rst_n low, synchronous) clears the byte count, the captured header
// fields and the result valid flag; the block is ready in the next cycle.
// ============================================================================
// EAP packet header parser and classifier
// Counts the bytes of a buffer, captures the header and gives one checked,
// classified result after the final byte.
// ============================================================================
module eap_packet_parse_classify_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    eppc_in_if.sink     i_in,
    eppc_out_if.source  o_out
);
    import eppc_pkg::*;

    // Running state for the buffer in progress.
    logic [15:0] r_count;
    logic [15:0] r_len;
    logic [7:0]  r_code;
    logic [7:0]  r_ident;
    logic [7:0]  r_type;
    logic [7:0]  r_vsize;

    logic [15:0] n_count;
    logic [15:0] n_len;
    logic [7:0]  n_code;
    logic [7:0]  n_ident;
    logic [7:0]  n_type;
    logic [7:0]  n_vsize;

    // Result register.
    logic        r_out_valid;
    t_out_beat   r_out;
    t_out_beat   w_result;

    logic        w_fire;
    logic        w_last;
    logic        w_req_resp;
    logic        w_bad;
    logic [16:0] w_chal_need;
    logic        w_chal_ok;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_fire      = i_in.valid && i_in.ready;
    assign w_last      = w_fire && i_in.data.last_byte;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Capture the incoming byte at its header offset and advance the count.
    always_comb begin
        n_len   = r_len;
        n_code  = r_code;
        n_ident = r_ident;
        n_type  = r_type;
        n_vsize = r_vsize;
        case (r_count)
            OFS_CODE:     n_code  = i_in.data.data_byte;
            OFS_IDENT:    n_ident = i_in.data.data_byte;
            OFS_LEN_HI:   n_len   = {i_in.data.data_byte, r_len[7:0]};
            OFS_LEN_LO:   n_len   = {r_len[15:8], i_in.data.data_byte};
            OFS_TYPE:     n_type  = i_in.data.data_byte;
            OFS_VAL_SIZE: n_vsize = i_in.data.data_byte;
            default:      ;
        endcase
        n_count = (r_count == CNT_MAX) ? r_count : r_count + 16'd1;
    end

    // Check the header and classify the packet from the updated fields.
    always_comb begin
        w_req_resp  = (n_code == CODE_REQUEST) || (n_code == CODE_RESPONSE);
        w_bad       = (n_count < HDR_LEN) || (n_len < HDR_LEN) || (n_len > n_count) ||
                      (w_req_resp && (n_len < REQ_MIN_LEN));
        w_chal_need = {1'b0, CHAL_VAL_OFS} + {9'd0, n_vsize};
        w_chal_ok   = (n_code == CODE_REQUEST) && (n_type == TYPE_MD5) &&
                      (n_len > REQ_MIN_LEN) && (n_vsize != 8'd0) &&
                      ({1'b0, n_len} >= w_chal_need);

        w_result                  = '0;
        w_result.code             = n_code;
        w_result.identifier       = n_ident;
        w_result.packet_length    = n_len;
        w_result.event_res        = EV_UNSUPPORTED;
        if (w_bad) begin
            w_result.status = 1'b1;
        end else begin
            w_result.status = 1'b0;
            if (w_req_resp) begin
                w_result.eap_type = n_type;
            end
            if (n_code == CODE_SUCCESS) begin
                w_result.event_res = EV_SUCCESS;
            end else if (n_code == CODE_FAILURE) begin
                w_result.event_res = EV_FAILURE;
            end else if (n_code == CODE_REQUEST && n_type == TYPE_IDENTITY) begin
                w_result.event_res = EV_IDENTITY;
            end else if (n_code == CODE_REQUEST && n_type == TYPE_MD5) begin
                w_result.event_res = EV_MD5_CHAL;
            end
            if (w_chal_ok) begin
                w_result.challenge_valid  = 1'b1;
                w_result.challenge_length = n_vsize;
            end
        end
    end

    // Header state: updated on every byte beat, cleared after the final one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_last) begin
            r_count <= '0;
            r_len   <= '0;
            r_code  <= '0;
            r_ident <= '0;
            r_type  <= '0;
            r_vsize <= '0;
        end else if (w_fire) begin
            r_count <= n_count;
            r_len   <= n_len;
            r_code  <= n_code;
            r_ident <= n_ident;
            r_type  <= n_type;
            r_vsize <= n_vsize;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_last) begin
            r_out <= w_result;
        end
    end

    // A malformed packet never carries a type or challenge.
    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status) |->
            (r_out.event_res == EV_UNSUPPORTED && r_out.eap_type == 8'd0 &&
             r_out.challenge_valid == 1'b0 && r_out.challenge_length == 8'd0))
        else $error("malformed result carries type or challenge fields");

    // A valid challenge only comes with an MD5 request and a nonzero size.
    a_chal_md5: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.challenge_valid) |->
            (r_out.event_res == EV_MD5_CHAL && r_out.challenge_length != 8'd0))
        else $error("challenge flagged outside an MD5 request");

    // A well-formed packet has a length of at least the header.
    a_good_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.status) |-> (r_out.packet_length >= HDR_LEN))
        else $error("well-formed result with a short length field");

    // The final beat produces a result and restarts the byte count.
    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last |=> (r_out_valid && r_count == 16'd0))
        else $error("final beat did not yield a result or clear the count");

endmodule
